@@ hdl/pxw_pkg.sv @@
// Shared types and constants for the dithered RGB565 pixel writer.
// Holds the request, configuration and stage payload structs used by every
// pipeline stage; depends on nothing.
package pxw_pkg;

    // Bit positions of the packed colour fields.
    localparam int RED_SHIFT   = 11;
    localparam int GREEN_SHIFT = 5;
    localparam int BLUE_SHIFT  = 0;

    // Buffer codes on the target field. The spare code is not a buffer of its
    // own and is decoded as the pixmap.
    localparam logic [1:0] TGT_BACKING = 2'd0;
    localparam logic [1:0] TGT_SCREEN  = 2'd1;
    localparam logic [1:0] TGT_PIXMAP  = 2'd2;
    localparam logic [1:0] TGT_SPARE   = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXMAP_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXMAP_HEIGHT = 3'd5;

    typedef struct packed {
        logic [15:0] screen_width;
        logic [15:0] screen_height;
        logic [15:0] step_x;
        logic [15:0] step_y;
        logic [15:0] pixmap_width;
        logic [15:0] pixmap_height;
    } cfg_t;

    typedef struct packed {
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [1:0]  target;
        logic        dither_on;
        logic        xor_on;
    } req_t;

    // After clipping, scaling products and offset products.
    typedef struct packed {
        logic        in_bounds;
        logic [1:0]  wtarget;
        logic [31:0] prod_x;
        logic [31:0] prod_y;
        logic [15:0] red_m;
        logic [15:0] green_m;
        logic [15:0] blue_m;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        dither_on;
        logic        xor_on;
        logic        x_lo;
        logic [1:0]  y_lo;
    } s1_t;

    // After the divide by 255, the offset sum and the threshold look-up.
    typedef struct packed {
        logic        in_bounds;
        logic [1:0]  wtarget;
        logic [31:0] offset;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [2:0]  th8;
        logic [1:0]  th4;
        logic        dither_on;
        logic        xor_on;
    } s2_t;

    typedef struct packed {
        logic        write_valid;
        logic [1:0]  write_target;
        logic [31:0] word_offset;
        logic [15:0] pixel_word;
        logic        xor_write;
        logic        dirty_mark;
    } res_t;

endpackage

@@ hdl/pxw_front.sv @@
// First pipeline stage: target decode, clipping and all multiplications.
// Depends on pxw_pkg.
module pxw_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  pxw_pkg::req_t up_data,
    input  pxw_pkg::cfg_t cfg,
    output logic          busy,
    input  logic          down_busy,
    output logic          valid,
    output pxw_pkg::s1_t  data
);
    import pxw_pkg::*;

    logic  valid_reg, valid_next;
    s1_t   data_reg, data_next;
    logic  pixmap;
    logic [15:0] lim_w, lim_h, sx, sy;

    assign busy = valid_reg && down_busy;

    always_comb
    begin
        pixmap = up_data.target[1];
        lim_w  = pixmap ? cfg.pixmap_width  : cfg.screen_width;
        lim_h  = pixmap ? cfg.pixmap_height : cfg.screen_height;
        sx     = pixmap ? 16'd1             : cfg.step_x;
        sy     = pixmap ? cfg.pixmap_width  : cfg.step_y;

        data_next           = data_reg;
        data_next.in_bounds = (up_data.pos_x < lim_w) && (up_data.pos_y < lim_h);
        data_next.wtarget   = pixmap ? TGT_PIXMAP : up_data.target;
        data_next.prod_x    = {16'd0, up_data.pos_x} * {16'd0, sx};
        data_next.prod_y    = {16'd0, up_data.pos_y} * {16'd0, sy};
        data_next.red_m     = {8'd0, up_data.red}   * 16'd248;
        data_next.green_m   = {8'd0, up_data.green} * 16'd252;
        data_next.blue_m    = {8'd0, up_data.blue}  * 16'd248;
        data_next.red       = up_data.red;
        data_next.green     = up_data.green;
        data_next.blue      = up_data.blue;
        data_next.dither_on = up_data.dither_on;
        data_next.xor_on    = up_data.xor_on;
        data_next.x_lo      = up_data.pos_x[0];
        data_next.y_lo      = up_data.pos_y[1:0];

        valid_next = busy ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !busy)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

@@ hdl/pxw_mid.sv @@
// Second pipeline stage: divide by 255, offset sum and dither thresholds.
// Depends on pxw_pkg.
module pxw_mid (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    input  pxw_pkg::s1_t up_data,
    output logic         busy,
    input  logic         down_busy,
    output logic         valid,
    output pxw_pkg::s2_t data
);
    import pxw_pkg::*;

    // Exact quotient by 255 for every value below 255 * 256.
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = {1'b0, v} + {9'd0, v[15:8]} + 17'd1;
        return t[15:8];
    endfunction

    // Ordered dither matrix for the five-bit channels.
    function automatic logic [2:0] thr8(input logic xb, input logic [1:0] yb);
        logic [2:0] t;
        case ({xb, yb})
            3'b000:  t = 3'd0;
            3'b001:  t = 3'd4;
            3'b010:  t = 3'd2;
            3'b011:  t = 3'd6;
            3'b100:  t = 3'd1;
            3'b101:  t = 3'd5;
            3'b110:  t = 3'd3;
            3'b111:  t = 3'd7;
            default: t = 3'd0;
        endcase
        return t;
    endfunction

    // Ordered dither matrix for the six-bit channel.
    function automatic logic [1:0] thr4(input logic xb, input logic yb);
        logic [1:0] t;
        case ({xb, yb})
            2'b00:   t = 2'd0;
            2'b01:   t = 2'd2;
            2'b10:   t = 2'd1;
            2'b11:   t = 2'd3;
            default: t = 2'd0;
        endcase
        return t;
    endfunction

    logic valid_reg, valid_next;
    s2_t  data_reg, data_next;

    assign busy = valid_reg && down_busy;

    always_comb
    begin
        data_next           = data_reg;
        data_next.in_bounds = up_data.in_bounds;
        data_next.wtarget   = up_data.wtarget;
        data_next.offset    = up_data.prod_x + up_data.prod_y;
        data_next.red       = up_data.dither_on ? div255(up_data.red_m)   : up_data.red;
        data_next.green     = up_data.dither_on ? div255(up_data.green_m) : up_data.green;
        data_next.blue      = up_data.dither_on ? div255(up_data.blue_m)  : up_data.blue;
        data_next.th8       = thr8(up_data.x_lo, up_data.y_lo);
        data_next.th4       = thr4(up_data.x_lo, up_data.y_lo[0]);
        data_next.dither_on = up_data.dither_on;
        data_next.xor_on    = up_data.xor_on;

        valid_next = busy ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !busy)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

@@ hdl/pxw_out.sv @@
// Last pipeline stage: dither rounding, 5-6-5 packing and the result register.
// Depends on pxw_pkg.
module pxw_out (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          up_valid,
    input  pxw_pkg::s2_t  up_data,
    output logic          busy,
    input  logic          down_busy,
    output logic          valid,
    output pxw_pkg::res_t data
);
    import pxw_pkg::*;

    logic  valid_reg, valid_next;
    res_t  data_reg, data_next;
    logic [7:0]  r_d, g_d, b_d;
    logic [31:0] packed_word;

    assign busy = valid_reg && down_busy;

    always_comb
    begin
        r_d = up_data.red;
        g_d = up_data.green;
        b_d = up_data.blue;
        if (up_data.dither_on)
        begin
            // The scaled channels never exceed 252, so the bump stays in range.
            if (up_data.red[2:0] > up_data.th8)
            begin
                r_d = up_data.red + 8'd8;
            end
            if (up_data.blue[2:0] > up_data.th8)
            begin
                b_d = up_data.blue + 8'd8;
            end
            if (up_data.green[1:0] > up_data.th4)
            begin
                g_d = up_data.green + 8'd4;
            end
        end

        packed_word = (32'(r_d[7:3]) << RED_SHIFT) | (32'(g_d[7:2]) << GREEN_SHIFT)
                    | (32'(b_d[7:3]) << BLUE_SHIFT);

        data_next              = data_reg;
        data_next.write_valid  = up_data.in_bounds;
        data_next.write_target = up_data.wtarget;
        if (up_data.in_bounds)
        begin
            data_next.word_offset = up_data.offset;
            data_next.pixel_word  = packed_word[15:0];
            data_next.xor_write   = up_data.xor_on;
            data_next.dirty_mark  = (up_data.wtarget == TGT_BACKING);
        end
        else
        begin
            data_next.word_offset = 32'd0;
            data_next.pixel_word  = 16'd0;
            data_next.xor_write   = 1'b0;
            data_next.dirty_mark  = 1'b0;
        end

        valid_next = busy ? valid_reg : up_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && !busy)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;
endmodule

@@ hdl/dithered_rgb565_pixel_writer.sv @@
// Top level of the dithered RGB565 pixel writer: configuration registers and
// the three-stage pipeline. Depends on pxw_pkg, pxw_front, pxw_mid and pxw_out.
//
// Usage. A pixel request is presented on pos_x, pos_y, red, green, blue, target,
// dither_on and xor_on with req_valid high; it is taken at a rising edge where
// req_stall is low. Each request produces exactly one write descriptor on the
// result channel, shown with res_valid and taken when res_stall is low.
// The geometry registers are written through cfg_we, cfg_index and cfg_data
// while no request is in flight; indexes beyond the six registers are ignored.
// A request taken at one edge moves through the front, middle and result
// registers in turn; the descriptor leaves at an edge where res_stall is low.
// While the receiver does not stall, the pipeline sustains one request per
// clock: the front stage holds the two 16 by 16 offset multipliers and the
// colour scalers, the middle stage the offset adder and the divide by 255,
// and the last stage the rounding and packing.
// Reset clears the three stage valid bits and loads the registers with their
// defaults (240 by 320 screen, steps 1 and 240, empty pixmap).
// When the receiver stalls, the result register holds its request unchanged,
// and the earlier stages keep filling until all three are occupied; only then
// is req_stall raised, so up to three requests wait inside the block.
module dithered_rgb565_pixel_writer (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [pxw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data,
    // Pixel request channel.
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [1:0]  target,
    input  logic        dither_on,
    input  logic        xor_on,
    // Write descriptor channel.
    output logic        res_valid,
    input  logic        res_stall,
    output logic        write_valid,
    output logic [1:0]  write_target,
    output logic [31:0] word_offset,
    output logic [15:0] pixel_word,
    output logic        xor_write,
    output logic        dirty_mark
);
    import pxw_pkg::*;

    cfg_t cfg_reg, cfg_next;
    req_t req;
    s1_t  s1_data;
    s2_t  s2_data;
    res_t res;
    logic s1_valid, s2_valid;
    logic s1_busy, s2_busy, s3_busy;

    // Register writes are accepted unconditionally; unknown indexes fall through.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data;
                CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data;
                CFG_STEP_X:        cfg_next.step_x        = cfg_data;
                CFG_STEP_Y:        cfg_next.step_y        = cfg_data;
                CFG_PIXMAP_WIDTH:  cfg_next.pixmap_width  = cfg_data;
                CFG_PIXMAP_HEIGHT: cfg_next.pixmap_height = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_width  <= 16'd240;
            cfg_reg.screen_height <= 16'd320;
            cfg_reg.step_x        <= 16'd1;
            cfg_reg.step_y        <= 16'd240;
            cfg_reg.pixmap_width  <= 16'd0;
            cfg_reg.pixmap_height <= 16'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        req.pos_x     = pos_x;
        req.pos_y     = pos_y;
        req.red       = red;
        req.green     = green;
        req.blue      = blue;
        req.target    = target;
        req.dither_on = dither_on;
        req.xor_on    = xor_on;
    end

    pxw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (req_valid),
        .up_data   (req),
        .cfg       (cfg_reg),
        .busy      (s1_busy),
        .down_busy (s2_busy),
        .valid     (s1_valid),
        .data      (s1_data)
    );

    pxw_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s1_valid),
        .up_data   (s1_data),
        .busy      (s2_busy),
        .down_busy (s3_busy),
        .valid     (s2_valid),
        .data      (s2_data)
    );

    pxw_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (s2_valid),
        .up_data   (s2_data),
        .busy      (s3_busy),
        .down_busy (res_stall),
        .valid     (res_valid),
        .data      (res)
    );

    assign req_stall    = s1_busy;
    assign write_valid  = res.write_valid;
    assign write_target = res.write_target;
    assign word_offset  = res.word_offset;
    assign pixel_word   = res.pixel_word;
    assign xor_write    = res.xor_write;
    assign dirty_mark   = res.dirty_mark;

    // The request side only backs up once every stage holds a request.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (res_valid && res_stall && s1_valid && s2_valid))
        else $error("request stalled while the pipeline has a free stage");

    // A clipped pixel carries no offset, colour or dirty mark.
    a_clipped_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !write_valid) |->
        (word_offset == 32'd0 && pixel_word == 16'd0 && !xor_write && !dirty_mark))
        else $error("clipped pixel produced a non-zero write descriptor");

    // Dirty marks belong only to valid writes into the backing buffer.
    a_dirty_backing: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && dirty_mark) |-> (write_valid && write_target == TGT_BACKING))
        else $error("dirty mark on a write outside the backing buffer");

    // The spare target code is always folded onto the pixmap.
    a_target_decoded: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (write_target != TGT_SPARE))
        else $error("undecoded target code reached the result");
endmodule

@@ sim/pxw_write_checker.sv @@
// Checker for the dithered RGB565 pixel writer: follows the register writes,
// predicts the write descriptor of every accepted pixel request and compares
// it with what the block hands out. Depends on pxw_pkg.
`timescale 1ns / 100ps

module pxw_write_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [pxw_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [15:0] pos_x,
    input  logic [15:0] pos_y,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [1:0]  target,
    input  logic        dither_on,
    input  logic        xor_on,
    input  logic        res_valid,
    input  logic        res_stall,
    input  logic        write_valid,
    input  logic [1:0]  write_target,
    input  logic [31:0] word_offset,
    input  logic [15:0] pixel_word,
    input  logic        xor_write,
    input  logic        dirty_mark,
    output int          mismatches,
    output int          writes_due,
    output int          writes_checked,
    output int          writes_inside
);
    import pxw_pkg::*;

    cfg_t geometry;
    res_t pending_writes[$];

    // Works out the single write descriptor caused by one pixel request.
    function automatic res_t predict_write(input req_t px, input cfg_t g);
        res_t        w;
        logic [15:0] lim_x;
        logic [15:0] lim_y;
        logic [31:0] stride_x;
        logic [31:0] stride_y;
        logic [31:0] packed_colour;
        logic [2:0]  th8;
        logic [1:0]  th4;
        int          r;
        int          gr;
        int          b;
        w = '0;
        if (px.target[1]) begin
            // The pixmap bit wins, so code three also lands in the pixmap.
            w.write_target = TGT_PIXMAP;
            lim_x    = g.pixmap_width;
            lim_y    = g.pixmap_height;
            stride_x = 32'd1;
            stride_y = {16'd0, g.pixmap_width};
        end
        else begin
            w.write_target = px.target;
            lim_x    = g.screen_width;
            lim_y    = g.screen_height;
            stride_x = {16'd0, g.step_x};
            stride_y = {16'd0, g.step_y};
        end
        if (px.pos_x < lim_x && px.pos_y < lim_y) begin
            r  = int'(px.red);
            gr = int'(px.green);
            b  = int'(px.blue);
            if (px.dither_on) begin
                r  = r * 248 / 255;
                b  = b * 248 / 255;
                gr = gr * 252 / 255;
                // The 2x4 matrix is the bit-reversed row times two plus the
                // column parity; the 2x2 one follows the same rule.
                th8 = {px.pos_y[0], px.pos_y[1], px.pos_x[0]};
                th4 = {px.pos_y[0], px.pos_x[0]};
                if (3'(r % 8) > th8)
                    r = r + 8;
                if (3'(b % 8) > th8)
                    b = b + 8;
                if (2'(gr % 4) > th4)
                    gr = gr + 4;
            end
            packed_colour = ((r >> 3) << RED_SHIFT) | ((gr >> 2) << GREEN_SHIFT)
                          | ((b >> 3) << BLUE_SHIFT);
            w.write_valid = 1'b1;
            w.pixel_word  = packed_colour[15:0];
            w.word_offset = stride_x * {16'd0, px.pos_x} + stride_y * {16'd0, px.pos_y};
            w.xor_write   = px.xor_on;
            w.dirty_mark  = (w.write_target == TGT_BACKING);
        end
        return w;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        req_t px;
        res_t want;
        if (!rst_n) begin
            geometry.screen_width  = 16'd240;
            geometry.screen_height = 16'd320;
            geometry.step_x        = 16'd1;
            geometry.step_y        = 16'd240;
            geometry.pixmap_width  = 16'd0;
            geometry.pixmap_height = 16'd0;
            pending_writes.delete();
            writes_due = 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SCREEN_WIDTH:  geometry.screen_width  = cfg_data;
                    CFG_SCREEN_HEIGHT: geometry.screen_height = cfg_data;
                    CFG_STEP_X:        geometry.step_x        = cfg_data;
                    CFG_STEP_Y:        geometry.step_y        = cfg_data;
                    CFG_PIXMAP_WIDTH:  geometry.pixmap_width  = cfg_data;
                    CFG_PIXMAP_HEIGHT: geometry.pixmap_height = cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && !req_stall) begin
                px = '{pos_x: pos_x, pos_y: pos_y, red: red, green: green, blue: blue,
                       target: target, dither_on: dither_on, xor_on: xor_on};
                pending_writes.push_back(predict_write(px, geometry));
            end
            if (res_valid && !res_stall) begin
                if (pending_writes.size() == 0) begin
                    mismatches++;
                    $display("%0t: descriptor with no request outstanding, expected none, actual %0h",
                             $time, {write_valid, write_target, word_offset, pixel_word,
                                     xor_write, dirty_mark});
                end
                else begin
                    want = pending_writes.pop_front();
                    check_field("write_valid", 32'(want.write_valid), 32'(write_valid));
                    check_field("write_target", 32'(want.write_target), 32'(write_target));
                    check_field("word_offset", want.word_offset, word_offset);
                    check_field("pixel_word", 32'(want.pixel_word), 32'(pixel_word));
                    check_field("xor_write", 32'(want.xor_write), 32'(xor_write));
                    check_field("dirty_mark", 32'(want.dirty_mark), 32'(dirty_mark));
                    writes_checked++;
                    if (want.write_valid)
                        writes_inside++;
                end
            end
            writes_due = pending_writes.size();
        end
    end

    initial
    begin
        mismatches     = 0;
        writes_checked = 0;
        writes_inside  = 0;
        writes_due     = 0;
    end

endmodule

@@ sim/tb_dithered_rgb565_pixel_writer.sv @@
// Top of the pixel writer testbench: clock, reset, request and result drivers,
// register loading and the verdict. Depends on pxw_pkg, the block itself and
// pxw_write_checker, which does all prediction and comparison.
`timescale 1ns / 100ps

module tb_dithered_rgb565_pixel_writer;
    import pxw_pkg::*;

    // The block is three stages deep; the settle pauses are reckoned from that.
    localparam int PIPE_LATENCY    = 3;
    // Longest run of cycles in which neither channel may move before we give up.
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    // Percentage of cycles in which each side idles when idling is enabled.
    localparam int IDLE_PERCENT    = 36;
    localparam int HOLD_OFF_CYCLES = 60;
    // An index above the six registers; the block must ignore writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;
    logic        req_valid;
    logic        req_stall;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [1:0]  target;
    logic        dither_on;
    logic        xor_on;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic        write_valid;
    logic [1:0]  write_target;
    logic [31:0] word_offset;
    logic [15:0] pixel_word;
    logic        xor_write;
    logic        dirty_mark;

    int mismatches;
    int writes_due;
    int writes_checked;
    int writes_inside;

    // Stimulus-side copy of the geometry, used only to aim the random
    // coordinates at the edges of whichever buffer a request targets.
    cfg_t cur;
    bit   sender_idles = 1'b1;
    bit   sink_idles   = 1'b1;
    int   hold_ask     = 0;
    int   requests_sent = 0;
    int   settings_used = 1;
    int   quiet_cycles  = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dithered_rgb565_pixel_writer u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .target       (target),
        .dither_on    (dither_on),
        .xor_on       (xor_on),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .write_valid  (write_valid),
        .write_target (write_target),
        .word_offset  (word_offset),
        .pixel_word   (pixel_word),
        .xor_write    (xor_write),
        .dirty_mark   (dirty_mark)
    );

    pxw_write_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .red            (red),
        .green          (green),
        .blue           (blue),
        .target         (target),
        .dither_on      (dither_on),
        .xor_on         (xor_on),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .write_valid    (write_valid),
        .write_target   (write_target),
        .word_offset    (word_offset),
        .pixel_word     (pixel_word),
        .xor_write      (xor_write),
        .dirty_mark     (dirty_mark),
        .mismatches     (mismatches),
        .writes_due     (writes_due),
        .writes_checked (writes_checked),
        .writes_inside  (writes_inside)
    );

    // Result side. The stall is decided at every falling edge: a long hold-off
    // when the stimulus asks for one, otherwise random stalls when enabled.
    // The hold-off is counted here, so the sender is free to keep offering
    // requests while the block backs up.
    always @(negedge clk)
    begin
        int stall_left;
        if (hold_ask != 0) begin
            stall_left = hold_ask;
            hold_ask   = 0;
        end
        if (stall_left > 0) begin
            res_stall <= 1'b1;
            stall_left--;
        end
        else begin
            res_stall <= sink_idles && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Watchdog: a correct block never sits this long with neither channel
    // moving, however the stalls fall.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_CYCLES) begin
                $display("Watchdog: no request or result moved for %0d cycles.", quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    function automatic req_t make_pixel(input logic [15:0] x, input logic [15:0] y,
                                        input logic [7:0] r, input logic [7:0] g,
                                        input logic [7:0] b, input logic [1:0] tgt,
                                        input logic dith, input logic xr);
        req_t px;
        px = '{pos_x: x, pos_y: y, red: r, green: g, blue: b,
               target: tgt, dither_on: dith, xor_on: xr};
        return px;
    endfunction

    function automatic cfg_t make_geometry(input logic [15:0] w, input logic [15:0] h,
                                           input logic [15:0] sx, input logic [15:0] sy,
                                           input logic [15:0] pw, input logic [15:0] ph);
        cfg_t g;
        g = '{screen_width: w, screen_height: h, step_x: sx, step_y: sy,
              pixmap_width: pw, pixmap_height: ph};
        return g;
    endfunction

    // Most coordinates fall inside the buffer, a good share sit right on the
    // clipping edge, and the rest use the whole 16-bit range.
    function automatic logic [15:0] pick_coord(input logic [15:0] lim);
        logic [15:0] v;
        int          dice;
        dice = $urandom_range(99);
        if (lim != 16'd0 && dice < 70)
            v = 16'($urandom_range(lim - 16'd1));
        else if (dice < 80)
            v = lim;
        else if (dice < 85)
            v = lim - 16'd1;
        else
            v = 16'($urandom);
        return v;
    endfunction

    function automatic req_t random_pixel();
        req_t px;
        px.target    = 2'($urandom_range(3));
        px.pos_x     = pick_coord(px.target[1] ? cur.pixmap_width  : cur.screen_width);
        px.pos_y     = pick_coord(px.target[1] ? cur.pixmap_height : cur.screen_height);
        px.red       = 8'($urandom);
        px.green     = 8'($urandom);
        px.blue      = 8'($urandom);
        px.dither_on = 1'($urandom_range(1));
        px.xor_on    = 1'($urandom_range(1));
        return px;
    endfunction

    // Offers one request, entered and left at a falling edge. Valid is left
    // high on return so that back-to-back requests never drop it; whatever
    // runs next either drives a new request or lowers it, once per edge.
    task automatic send_pixel(input req_t px);
        while (sender_idles && $urandom_range(99) < IDLE_PERCENT) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        pos_x     <= px.pos_x;
        pos_y     <= px.pos_y;
        red       <= px.red;
        green     <= px.green;
        blue      <= px.blue;
        target    <= px.target;
        dither_on <= px.dither_on;
        xor_on    <= px.xor_on;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
        requests_sent++;
    endtask

    // Stops offering and waits until every outstanding descriptor has come back.
    task automatic drain_results();
        req_valid <= 1'b0;
        while (writes_due != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
    endtask

    // Registers are only touched with the pipeline empty: drain, let the
    // stages settle, then write all six in consecutive cycles.
    task automatic load_geometry(input cfg_t g);
        drain_results();
        repeat (PIPE_LATENCY + 1)
            @(negedge clk);
        write_reg(CFG_SCREEN_WIDTH,  g.screen_width);
        write_reg(CFG_SCREEN_HEIGHT, g.screen_height);
        write_reg(CFG_STEP_X,        g.step_x);
        write_reg(CFG_STEP_Y,        g.step_y);
        write_reg(CFG_PIXMAP_WIDTH,  g.pixmap_width);
        write_reg(CFG_PIXMAP_HEIGHT, g.pixmap_height);
        cfg_we <= 1'b0;
        cur = g;
        settings_used++;
    endtask

    initial
    begin
        int phase;
        int n;
        // Every input is known from time zero.
        cfg_we    = 1'b0;
        cfg_index = CFG_SCREEN_WIDTH;
        cfg_data  = 16'd0;
        req_valid = 1'b0;
        pos_x     = 16'd0;
        pos_y     = 16'd0;
        red       = 8'd0;
        green     = 8'd0;
        blue      = 8'd0;
        target    = TGT_BACKING;
        dither_on = 1'b0;
        xor_on    = 1'b0;
        cur = make_geometry(16'd240, 16'd320, 16'd1, 16'd240, 16'd0, 16'd0);

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, first with the reset geometry: both corners of the
        // screen, the first pixel past each edge, the far corner of the
        // coordinate space, the empty pixmap and target code three.
        send_pixel(make_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, TGT_BACKING, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd239, 16'd319, 8'h00, 8'h00, 8'h00, TGT_SCREEN, 1'b1, 1'b1));
        send_pixel(make_pixel(16'd240, 16'd0, 8'h80, 8'h40, 8'h20, TGT_BACKING, 1'b0, 1'b0));
        send_pixel(make_pixel(16'd0, 16'd320, 8'h80, 8'h40, 8'h20, TGT_SCREEN, 1'b0, 1'b1));
        send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 8'hFF, 8'h00, 8'hFF, TGT_BACKING, 1'b1, 1'b1));
        send_pixel(make_pixel(16'd0, 16'd0, 8'h12, 8'h34, 8'h56, TGT_PIXMAP, 1'b0, 1'b0));
        send_pixel(make_pixel(16'd0, 16'd0, 8'h12, 8'h34, 8'h56, TGT_SPARE, 1'b1, 1'b1));
        // Walk the dither matrices through both column parities and all row phases.
        send_pixel(make_pixel(16'd0, 16'd0, 8'h5A, 8'hA7, 8'h33, TGT_SCREEN, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd1, 16'd1, 8'h5A, 8'hA7, 8'h33, TGT_SCREEN, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd0, 16'd2, 8'h5A, 8'hA7, 8'h33, TGT_BACKING, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd1, 16'd3, 8'h5A, 8'hA7, 8'h33, TGT_BACKING, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd1, 16'd2, 8'h84, 8'h42, 8'h21, TGT_SCREEN, 1'b0, 1'b1));

        // Largest screen and steps, so the offset wraps past 32 bits, and a
        // small pixmap whose corners are probed. The unused index is written
        // as well and must change nothing.
        load_geometry(make_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16, 16'd8));
        @(negedge clk);
        write_reg(CFG_UNUSED, 16'hFFFF);
        cfg_we <= 1'b0;
        @(negedge clk);
        send_pixel(make_pixel(16'hFFFE, 16'hFFFE, 8'hFF, 8'hFF, 8'hFF, TGT_SCREEN, 1'b0, 1'b0));
        send_pixel(make_pixel(16'd15, 16'd7, 8'hC3, 8'h3C, 8'h99, TGT_SPARE, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd16, 16'd7, 8'hC3, 8'h3C, 8'h99, TGT_PIXMAP, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd15, 16'd8, 8'hC3, 8'h3C, 8'h99, TGT_PIXMAP, 1'b1, 1'b0));
        send_pixel(make_pixel(16'd7, 16'd3, 8'h07, 8'h03, 8'hF8, TGT_PIXMAP, 1'b1, 1'b1));
        send_pixel(make_pixel(16'hFFFE, 16'd0, 8'h01, 8'hFE, 8'h7F, TGT_BACKING, 1'b0, 1'b1));

        // A zero width clips everything, even with rows available.
        load_geometry(make_geometry(16'd0, 16'd10, 16'd1, 16'd1, 16'd0, 16'd5));
        send_pixel(make_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, TGT_BACKING, 1'b0, 1'b0));
        send_pixel(make_pixel(16'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF, TGT_PIXMAP, 1'b0, 1'b0));

        // Random part, one geometry per phase. Phase four runs with no idling
        // on either side; phases one and five hold the result side off for a
        // long stretch while requests keep coming, so the block fills and
        // stalls its input; phase three pauses the sender until the pipeline
        // has emptied.
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: load_geometry(make_geometry(16'd240, 16'd320, 16'd1, 16'd240,
                                               16'd64, 16'd48));
                1: load_geometry(make_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                               16'hFFFF, 16'hFFFF));
                2: load_geometry(make_geometry(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
                3: load_geometry(make_geometry(16'd8, 16'd4, 16'd3, 16'd17, 16'd5, 16'd3));
                5: load_geometry(make_geometry(16'($urandom_range(1024, 1)),
                                               16'($urandom_range(1024, 1)),
                                               16'($urandom), 16'($urandom),
                                               16'($urandom_range(512, 1)),
                                               16'($urandom_range(512, 1))));
                6: load_geometry(make_geometry(16'd1, 16'd1, 16'h8000, 16'h0001,
                                               16'hFFFF, 16'd1));
                default: load_geometry(make_geometry(16'($urandom), 16'($urandom),
                                                     16'($urandom), 16'($urandom),
                                                     16'($urandom), 16'($urandom)));
            endcase
            sink_idles = (phase != 4);
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n == 100 && (phase == 1 || phase == 5))
                    hold_ask = HOLD_OFF_CYCLES;
                if (n == 100 && phase == 3)
                    drain_results();
                sender_idles = !(phase == 4 || ((phase == 1 || phase == 5) && n >= 100 && n < 120));
                send_pixel(random_pixel());
            end
        end

        drain_results();
        repeat (PIPE_LATENCY * 4)
            @(posedge clk);

        $display("Run covered %0d pixel requests across %0d register settings,", requests_sent,
                 settings_used);
        $display("with %0d descriptors compared, %0d of them inside their buffer.",
                 writes_checked, writes_inside);
        if (mismatches == 0 && writes_due == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
